@@ sv/pva_pkg.sv @@
// Shared types, codes and the velocity table for the voice allocator.
package pva_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_CTL      = 2'd2,
        OP_TICK     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STG_ATTACK  = 2'd0,
        STG_DECAY   = 2'd1,
        STG_SUSTAIN = 2'd2,
        STG_RELEASE = 2'd3
    } stage_t;

    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

    localparam logic [6:0] SUSTAIN_CTL  = 7'd64;
    localparam logic [6:0] PEDAL_ON_MIN = 7'd64;
    localparam int unsigned KEYS = 128;

    // datapath micro-operations issued by the sequencer
    typedef enum logic [4:0] {
        DP_NONE,
        DP_LATCH,
        DP_IDX_NEXT,
        DP_ON_SCAN,
        DP_ON_COMMIT,
        DP_OFF_SLOT,
        DP_PEDAL_SET,
        DP_PEDAL_SLOT,
        DP_HELD_CLEAR,
        DP_ATK_JUMP,
        DP_MUL_CNT_PEAK,
        DP_DIV_START_ATK,
        DP_DIV_START_DEC,
        DP_DIV_STEP,
        DP_ATK_FIN,
        DP_MUL_PEAK_SUS,
        DP_SUS_FIN,
        DP_MUL_F_SUS,
        DP_MUL_PEAK_M,
        DP_DEC_FIN,
        DP_MUL_GAIN_COEFF,
        DP_REL_FIN,
        DP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    sustain_ctl;
        logic    pedal_up;
        logic    active;
        stage_t  stage;
        logic    atk_end;
        logic    dec_end;
        logic    idx_last;
        logic    div_last;
        logic    out_busy;
    } dp_status_t;

    localparam longint unsigned VEL_DEN = 64'd204838300; // 100 * 127^3

    typedef logic [23:0] vel_rom_t [KEYS];

    // floor(0.7 * 2^24 * (v/127)^1.5), exact integer form
    function automatic logic [23:0] vel_peak(input longint unsigned v);
        longint unsigned t, a, q1, r1, q2, x, r, b;
        t  = 64'd49 * v * v * v;
        a  = t << 24;
        q1 = a / VEL_DEN;
        r1 = a % VEL_DEN;
        q2 = (r1 << 24) / VEL_DEN;
        x  = (q1 << 24) + q2;
        r  = 64'd0;
        b  = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[23:0];
    endfunction

    function automatic vel_rom_t build_vel_rom();
        vel_rom_t rom;
        for (int v = 0; v < KEYS; v++)
        begin
            rom[v] = vel_peak(longint'(v));
        end
        return rom;
    endfunction

    localparam vel_rom_t VEL_ROM = build_vel_rom();

endpackage

@@ sv/poly_voice_allocator_envelope.sv @@
// Polyphonic voice allocator with ADSR-style envelopes: top level.
// One event word at a time. A tick walks every voice through one shared multiplier and a
// radix-2 divider (24 steps), then reports one voice per cycle unless the output stalls.
// Reset clears all voices, pedal marks and control registers to their defaults at once;
// no clearing pass.
module poly_voice_allocator_envelope #(
    parameter int VOICES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [6:0]                    note,
    input  logic [6:0]                    velocity,
    input  logic [6:0]                    controller,
    input  logic [6:0]                    ctl_value,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pva_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [23:0]                   cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [$clog2(VOICES)-1:0]     voice_index,
    output logic [6:0]                    voice_key,
    output logic [23:0]                   level,
    output logic                          last
);

    pva_pkg::dp_cmd_t    cmd;
    pva_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    pva_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    pva_datapath #(
        .VOICES (VOICES),
        .IW     ($clog2(VOICES))
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .opcode      (opcode),
        .note        (note),
        .velocity    (velocity),
        .controller  (controller),
        .ctl_value   (ctl_value),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .voice_index (voice_index),
        .voice_key   (voice_key),
        .level       (level),
        .last        (last)
    );

endmodule

@@ sv/pva_datapath.sv @@
// Voice bank, pedal marks, config registers, multiplier, divider and output word register.
module pva_datapath #(
    parameter int VOICES = 16,
    parameter int IW     = $clog2(VOICES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pva_pkg::dp_cmd_t               cmd,
    output pva_pkg::dp_status_t            status,
    input  logic [1:0]                     opcode,
    input  logic [6:0]                     note,
    input  logic [6:0]                     velocity,
    input  logic [6:0]                     controller,
    input  logic [6:0]                     ctl_value,
    input  logic                           cfg_valid,
    input  logic [pva_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [23:0]                    cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [IW-1:0]                  voice_index,
    output logic [6:0]                     voice_key,
    output logic [23:0]                    level,
    output logic                           last
);

    // config
    logic [15:0] attack_len_reg, decay_len_reg;
    logic [23:0] sustain_reg, coeff_reg, thresh_reg;

    // latched item
    pva_pkg::opcode_t op_reg;
    logic [6:0] note_reg, vel_reg;
    logic       sus_ctl_reg, pedal_val_reg;

    // voice bank
    logic [VOICES-1:0]   active_reg;
    logic [6:0]          slot_key_reg   [VOICES];
    logic [31:0]         slot_age_reg   [VOICES];
    logic [23:0]         slot_peak_reg  [VOICES];
    logic [23:0]         slot_gain_reg  [VOICES];
    pva_pkg::stage_t     slot_stage_reg [VOICES];
    logic [15:0]         slot_count_reg [VOICES];
    logic [pva_pkg::KEYS-1:0] held_reg;
    logic                pedal_reg;
    logic [31:0]         age_cnt_reg;

    logic [IW-1:0] idx_reg, idx_next;

    // note-on scan trackers
    logic          match_found_reg, free_found_reg, old_found_reg;
    logic [IW-1:0] match_idx_reg, free_idx_reg, old_idx_reg;
    logic [31:0]   old_age_reg;

    // arithmetic
    logic [49:0] prod_reg;
    logic [24:0] mul_a, mul_b;
    logic [15:0] rem_reg, dvs_reg;
    logic [23:0] nlow_reg, quo_reg;
    logic [4:0]  div_cnt_reg;
    logic [16:0] div_trial, div_diff;
    logic        div_ge;

    logic [IW-1:0] out_idx_reg;
    logic [6:0]    out_key_reg;
    logic [23:0]   out_level_reg;
    logic          out_last_reg, out_valid_reg;

    logic [6:0]    cur_key;
    logic [23:0]   cur_peak, cur_gain, prod_hi;
    logic [15:0]   cur_count;
    logic [16:0]   cur_c;
    pva_pkg::stage_t cur_stage;
    logic          cur_active, idx_last, advance;
    logic          use_free, steal;
    logic [IW-1:0] chosen;
    logic [VOICES-1:0] above_mask;
    logic          none_above;

    assign cur_key    = slot_key_reg[idx_reg];
    assign cur_peak   = slot_peak_reg[idx_reg];
    assign cur_gain   = slot_gain_reg[idx_reg];
    assign cur_count  = slot_count_reg[idx_reg];
    assign cur_stage  = slot_stage_reg[idx_reg];
    assign cur_active = active_reg[idx_reg];
    assign cur_c      = {1'b0, cur_count} + 17'd1;
    assign prod_hi    = prod_reg[47:24];
    assign idx_last   = (idx_reg == IW'(VOICES - 1));
    assign idx_next   = idx_last ? '0 : idx_reg + IW'(1);

    assign use_free = free_found_reg && (!match_found_reg || free_idx_reg < match_idx_reg);
    assign steal    = !free_found_reg && !match_found_reg;
    assign chosen   = use_free ? free_idx_reg : (match_found_reg ? match_idx_reg : old_idx_reg);

    always_comb
    begin
        for (int j = 0; j < VOICES; j++)
        begin
            above_mask[j] = (IW'(j) > idx_reg);
        end
    end
    assign none_above = ~|(active_reg & above_mask);

    always_comb
    begin
        case (cmd.op)
            pva_pkg::DP_ON_SCAN,
            pva_pkg::DP_OFF_SLOT,
            pva_pkg::DP_PEDAL_SLOT,
            pva_pkg::DP_IDX_NEXT,
            pva_pkg::DP_ATK_JUMP,
            pva_pkg::DP_ATK_FIN,
            pva_pkg::DP_SUS_FIN,
            pva_pkg::DP_DEC_FIN,
            pva_pkg::DP_REL_FIN,
            pva_pkg::DP_EMIT:  advance = 1'b1;
            default:           advance = 1'b0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            pva_pkg::DP_MUL_CNT_PEAK:
            begin
                mul_a = {9'd0, cur_count};
                mul_b = {1'b0, cur_peak};
            end
            pva_pkg::DP_MUL_PEAK_SUS:
            begin
                mul_a = {1'b0, cur_peak};
                mul_b = {1'b0, sustain_reg};
            end
            pva_pkg::DP_MUL_F_SUS:
            begin
                mul_a = {1'b0, quo_reg};
                mul_b = 25'h100_0000 - {1'b0, sustain_reg};
            end
            pva_pkg::DP_MUL_PEAK_M:
            begin
                mul_a = {1'b0, cur_peak};
                mul_b = {1'b0, prod_hi};
            end
            pva_pkg::DP_MUL_GAIN_COEFF:
            begin
                mul_a = {1'b0, cur_gain};
                mul_b = {1'b0, coeff_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_trial = {rem_reg, nlow_reg[23]};
    assign div_ge    = div_trial >= {1'b0, dvs_reg};
    assign div_diff  = div_trial - {1'b0, dvs_reg};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_len_reg  <= 16'd480;
            decay_len_reg   <= 16'd4800;
            sustain_reg     <= 24'd8388608;
            coeff_reg       <= 24'd16776051;
            thresh_reg      <= 24'd1678;
            active_reg      <= '0;
            held_reg        <= '0;
            pedal_reg       <= 1'b0;
            age_cnt_reg     <= '0;
            idx_reg         <= '0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_found_reg   <= 1'b0;
            div_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    pva_pkg::CFG_ATTACK:    attack_len_reg <= cfg_data[15:0];
                    pva_pkg::CFG_DECAY:     decay_len_reg  <= cfg_data[15:0];
                    pva_pkg::CFG_SUSTAIN:   sustain_reg    <= cfg_data;
                    pva_pkg::CFG_RELEASE:   coeff_reg      <= cfg_data;
                    pva_pkg::CFG_THRESHOLD: thresh_reg     <= cfg_data;
                    default: ;
                endcase
            end

            if (advance)
            begin
                idx_reg <= idx_next;
            end

            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (cmd.op)
                pva_pkg::DP_LATCH:
                begin
                    idx_reg         <= '0;
                    match_found_reg <= 1'b0;
                    free_found_reg  <= 1'b0;
                    old_found_reg   <= 1'b0;
                end
                pva_pkg::DP_ON_SCAN:
                begin
                    if (!match_found_reg && cur_active && cur_key == note_reg)
                    begin
                        match_found_reg <= 1'b1;
                    end
                    if (!free_found_reg && !cur_active)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    old_found_reg <= 1'b1;
                end
                pva_pkg::DP_ON_COMMIT:
                begin
                    if (match_found_reg)
                    begin
                        active_reg[match_idx_reg] <= 1'b0;
                        held_reg[note_reg]        <= 1'b0;
                    end
                    if (steal)
                    begin
                        held_reg[slot_key_reg[old_idx_reg]] <= 1'b0;
                    end
                    active_reg[chosen] <= 1'b1;
                    age_cnt_reg        <= age_cnt_reg + 32'd1;
                end
                pva_pkg::DP_OFF_SLOT:
                begin
                    if (cur_active && cur_key == note_reg && cur_stage != pva_pkg::STG_RELEASE
                        && pedal_reg)
                    begin
                        held_reg[note_reg] <= 1'b1;
                    end
                end
                pva_pkg::DP_PEDAL_SET:  pedal_reg <= pedal_val_reg;
                pva_pkg::DP_HELD_CLEAR: held_reg  <= '0;
                pva_pkg::DP_DIV_START_ATK,
                pva_pkg::DP_DIV_START_DEC: div_cnt_reg <= 5'd24;
                pva_pkg::DP_DIV_STEP:      div_cnt_reg <= div_cnt_reg - 5'd1;
                pva_pkg::DP_REL_FIN:
                begin
                    if (prod_hi < thresh_reg)
                    begin
                        active_reg[idx_reg] <= 1'b0;
                    end
                end
                pva_pkg::DP_EMIT:       out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        case (cmd.op)
            pva_pkg::DP_LATCH:
            begin
                op_reg        <= pva_pkg::opcode_t'(opcode);
                note_reg      <= note;
                vel_reg       <= velocity;
                sus_ctl_reg   <= (controller == pva_pkg::SUSTAIN_CTL);
                pedal_val_reg <= (ctl_value >= pva_pkg::PEDAL_ON_MIN);
            end
            pva_pkg::DP_ON_SCAN:
            begin
                if (!match_found_reg && cur_active && cur_key == note_reg)
                begin
                    match_idx_reg <= idx_reg;
                end
                if (!free_found_reg && !cur_active)
                begin
                    free_idx_reg <= idx_reg;
                end
                if (!old_found_reg || slot_age_reg[idx_reg] < old_age_reg)
                begin
                    old_idx_reg <= idx_reg;
                    old_age_reg <= slot_age_reg[idx_reg];
                end
            end
            pva_pkg::DP_ON_COMMIT:
            begin
                slot_key_reg[chosen]   <= note_reg;
                slot_age_reg[chosen]   <= age_cnt_reg;
                slot_peak_reg[chosen]  <= pva_pkg::VEL_ROM[vel_reg];
                slot_gain_reg[chosen]  <= '0;
                slot_stage_reg[chosen] <= pva_pkg::STG_ATTACK;
                slot_count_reg[chosen] <= '0;
            end
            pva_pkg::DP_OFF_SLOT:
            begin
                if (cur_active && cur_key == note_reg && cur_stage != pva_pkg::STG_RELEASE
                    && !pedal_reg)
                begin
                    slot_stage_reg[idx_reg] <= pva_pkg::STG_RELEASE;
                end
            end
            pva_pkg::DP_PEDAL_SLOT:
            begin
                if (cur_active && cur_stage != pva_pkg::STG_RELEASE && held_reg[cur_key])
                begin
                    slot_stage_reg[idx_reg] <= pva_pkg::STG_RELEASE;
                end
            end
            pva_pkg::DP_ATK_JUMP:
            begin
                slot_gain_reg[idx_reg]  <= cur_peak;
                slot_stage_reg[idx_reg] <= pva_pkg::STG_DECAY;
                slot_count_reg[idx_reg] <= '0;
            end
            pva_pkg::DP_DIV_START_ATK:
            begin
                rem_reg  <= prod_reg[39:24];
                nlow_reg <= prod_reg[23:0];
                dvs_reg  <= attack_len_reg;
            end
            pva_pkg::DP_DIV_START_DEC:
            begin
                rem_reg  <= cur_count;
                nlow_reg <= '0;
                dvs_reg  <= decay_len_reg;
            end
            pva_pkg::DP_DIV_STEP:
            begin
                rem_reg  <= div_ge ? div_diff[15:0] : div_trial[15:0];
                nlow_reg <= {nlow_reg[22:0], 1'b0};
                quo_reg  <= {quo_reg[22:0], div_ge};
            end
            pva_pkg::DP_ATK_FIN:
            begin
                slot_gain_reg[idx_reg]  <= quo_reg;
                slot_count_reg[idx_reg] <= cur_c[15:0];
            end
            pva_pkg::DP_SUS_FIN:
            begin
                slot_gain_reg[idx_reg]  <= prod_hi;
                slot_stage_reg[idx_reg] <= pva_pkg::STG_SUSTAIN;
                slot_count_reg[idx_reg] <= cur_c[15:0];
            end
            pva_pkg::DP_DEC_FIN:
            begin
                slot_gain_reg[idx_reg]  <= cur_peak - prod_hi;
                slot_count_reg[idx_reg] <= cur_c[15:0];
            end
            pva_pkg::DP_REL_FIN:    slot_gain_reg[idx_reg] <= prod_hi;
            pva_pkg::DP_EMIT:
            begin
                out_idx_reg   <= idx_reg;
                out_key_reg   <= cur_key;
                out_level_reg <= cur_gain;
                out_last_reg  <= none_above;
            end
            default: ;
        endcase
    end

    assign status.op          = op_reg;
    assign status.sustain_ctl = sus_ctl_reg;
    assign status.pedal_up    = !pedal_val_reg;
    assign status.active      = cur_active;
    assign status.stage       = cur_stage;
    assign status.atk_end     = cur_c >= {1'b0, attack_len_reg};
    assign status.dec_end     = cur_c >= {1'b0, decay_len_reg};
    assign status.idx_last    = idx_last;
    assign status.div_last    = (div_cnt_reg == 5'd1);
    assign status.out_busy    = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign voice_index = out_idx_reg;
    assign voice_key   = out_key_reg;
    assign level       = out_level_reg;
    assign last        = out_last_reg;

endmodule

@@ sv/pva_ctrl.sv @@
// Sequencer: walks the voice bank for note events, ticks and pedal release, and drives datapath micro-operations.
module pva_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output pva_pkg::dp_cmd_t     cmd,
    input  pva_pkg::dp_status_t  status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ON_SCAN,
        S_ON_COMMIT,
        S_OFF,
        S_PEDAL,
        S_PED_SCAN,
        S_PED_CLR,
        S_T_SLOT,
        S_A_DIV0,
        S_A_DIV,
        S_A_FIN,
        S_S_FIN,
        S_D_DIV,
        S_D_MUL1,
        S_D_MUL2,
        S_D_FIN,
        S_R_FIN,
        S_E_SLOT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;
    state_t after_slot;

    // once the last voice is done with the envelope pass, go report
    assign after_slot = status.idx_last ? S_E_SLOT : S_T_SLOT;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pva_pkg::DP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.op     = pva_pkg::DP_LATCH;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (status.op)
                    pva_pkg::OP_NOTE_ON:  state_next = S_ON_SCAN;
                    pva_pkg::OP_NOTE_OFF: state_next = S_OFF;
                    pva_pkg::OP_CTL:      state_next = status.sustain_ctl ? S_PEDAL : S_IDLE;
                    pva_pkg::OP_TICK:     state_next = S_T_SLOT;
                    default:              state_next = S_IDLE;
                endcase
            end
            S_ON_SCAN:
            begin
                cmd.op = pva_pkg::DP_ON_SCAN;
                if (status.idx_last)
                begin
                    state_next = S_ON_COMMIT;
                end
            end
            S_ON_COMMIT:
            begin
                cmd.op     = pva_pkg::DP_ON_COMMIT;
                state_next = S_IDLE;
            end
            S_OFF:
            begin
                cmd.op = pva_pkg::DP_OFF_SLOT;
                if (status.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_PEDAL:
            begin
                cmd.op     = pva_pkg::DP_PEDAL_SET;
                state_next = status.pedal_up ? S_PED_SCAN : S_IDLE;
            end
            S_PED_SCAN:
            begin
                cmd.op = pva_pkg::DP_PEDAL_SLOT;
                if (status.idx_last)
                begin
                    state_next = S_PED_CLR;
                end
            end
            S_PED_CLR:
            begin
                cmd.op     = pva_pkg::DP_HELD_CLEAR;
                state_next = S_IDLE;
            end
            S_T_SLOT:
            begin
                if (!status.active)
                begin
                    cmd.op     = pva_pkg::DP_IDX_NEXT;
                    state_next = after_slot;
                end
                else
                begin
                    unique case (status.stage)
                        pva_pkg::STG_ATTACK:
                        begin
                            if (status.atk_end)
                            begin
                                cmd.op     = pva_pkg::DP_ATK_JUMP;
                                state_next = after_slot;
                            end
                            else
                            begin
                                cmd.op     = pva_pkg::DP_MUL_CNT_PEAK;
                                state_next = S_A_DIV0;
                            end
                        end
                        pva_pkg::STG_DECAY:
                        begin
                            if (status.dec_end)
                            begin
                                cmd.op     = pva_pkg::DP_MUL_PEAK_SUS;
                                state_next = S_S_FIN;
                            end
                            else
                            begin
                                cmd.op     = pva_pkg::DP_DIV_START_DEC;
                                state_next = S_D_DIV;
                            end
                        end
                        pva_pkg::STG_SUSTAIN:
                        begin
                            cmd.op     = pva_pkg::DP_IDX_NEXT;
                            state_next = after_slot;
                        end
                        pva_pkg::STG_RELEASE:
                        begin
                            cmd.op     = pva_pkg::DP_MUL_GAIN_COEFF;
                            state_next = S_R_FIN;
                        end
                        default:
                        begin
                            cmd.op     = pva_pkg::DP_IDX_NEXT;
                            state_next = after_slot;
                        end
                    endcase
                end
            end
            S_A_DIV0:
            begin
                cmd.op     = pva_pkg::DP_DIV_START_ATK;
                state_next = S_A_DIV;
            end
            S_A_DIV:
            begin
                cmd.op = pva_pkg::DP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_A_FIN;
                end
            end
            S_A_FIN:
            begin
                cmd.op     = pva_pkg::DP_ATK_FIN;
                state_next = after_slot;
            end
            S_S_FIN:
            begin
                cmd.op     = pva_pkg::DP_SUS_FIN;
                state_next = after_slot;
            end
            S_D_DIV:
            begin
                cmd.op = pva_pkg::DP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = S_D_MUL1;
                end
            end
            S_D_MUL1:
            begin
                cmd.op     = pva_pkg::DP_MUL_F_SUS;
                state_next = S_D_MUL2;
            end
            S_D_MUL2:
            begin
                cmd.op     = pva_pkg::DP_MUL_PEAK_M;
                state_next = S_D_FIN;
            end
            S_D_FIN:
            begin
                cmd.op     = pva_pkg::DP_DEC_FIN;
                state_next = after_slot;
            end
            S_R_FIN:
            begin
                cmd.op     = pva_pkg::DP_REL_FIN;
                state_next = after_slot;
            end
            S_E_SLOT:
            begin
                if (!status.active)
                begin
                    cmd.op     = pva_pkg::DP_IDX_NEXT;
                    state_next = status.idx_last ? S_IDLE : S_E_SLOT;
                end
                else if (!status.out_busy)
                begin
                    cmd.op     = pva_pkg::DP_EMIT;
                    state_next = status.idx_last ? S_IDLE : S_E_SLOT;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule
